@@ hdl/fsqm_pkg.sv @@
// ----------------------------------------------------------------------------
// fsqm_pkg
// Shared types and constants of the frame slot queue manager.
// ----------------------------------------------------------------------------
package fsqm_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int LEN_W      = 23;
    localparam int SEQ_W      = 32;
    localparam int SEL_W      = 3;
    localparam int IDX_OUT_W  = 3;
    localparam int DROP_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 200;
    localparam int OUT_USER_W = 3;
    localparam int OUT_PAD_W  = 2;

    localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = 23'd4;
    localparam logic [LEN_W-1:0] CAP_RESET       = 23'h400000;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATEST   = 2'd1;

    typedef enum logic [1:0] {
        ACT_BEGIN   = 2'd0,
        ACT_END     = 2'd1,
        ACT_TAKE    = 2'd2,
        ACT_RELEASE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_WRITING  = 2'd1,
        ST_PENDING  = 2'd2,
        ST_DECODING = 2'd3
    } t_slot_st;

    typedef enum logic [2:0] {
        RES_OK           = 3'd0,
        RES_REJECT       = 3'd1,
        RES_NO_SLOT      = 3'd2,
        RES_NONE_PENDING = 3'd3,
        RES_WRONG_STATE  = 3'd4
    } t_result;

    typedef struct packed {
        logic              load;
        logic              scan_clr;
        logic              scan_rd;
        logic [SLOT_W-1:0] scan_addr;
        logic              apply;
    } t_dp_cmd;

    typedef struct packed {
        logic need_scan;
    } t_dp_sts;

endpackage

@@ hdl/fsqm_ctrl.sv @@
// ----------------------------------------------------------------------------
// fsqm_ctrl
// Sequencer of the frame slot queue manager: accepts one action, runs the
// pending-slot search when needed and hands the result to the output register.
// ----------------------------------------------------------------------------
module fsqm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output fsqm_pkg::t_dp_cmd o_cmd,
    input  fsqm_pkg::t_dp_sts i_sts
);
    import fsqm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_FINISH = 5'b01000,
        S_APPLY  = 5'b10000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [SLOT_W-1:0] r_cnt;
    logic [SLOT_W-1:0] n_cnt;
    logic              r_out_vld;
    logic              n_out_vld;
    logic              w_out_free;

    assign w_out_free      = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        o_cmd           = '0;
        o_cmd.scan_addr = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.scan_clr = 1'b1;
                n_cnt          = '0;
                if (i_sts.need_scan) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (r_cnt == SLOT_W'(SLOTS - 1)) begin
                    n_state = S_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FINISH: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.apply) begin
            n_out_vld = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

@@ hdl/fsqm_datapath.sv @@
// ----------------------------------------------------------------------------
// fsqm_datapath
// Slot states, slot sequence and length memory, pending-slot search, totals,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module fsqm_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fsqm_pkg::t_dp_cmd                   i_cmd,
    output fsqm_pkg::t_dp_sts                   o_sts,
    input  logic [fsqm_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic [fsqm_pkg::IN_USER_W-1:0]      i_in_user,
    input  logic                                i_cfg_wr,
    input  logic [fsqm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fsqm_pkg::LEN_W-1:0]          i_cfg_data,
    output logic [fsqm_pkg::OUT_DATA_W-1:0]     o_out_data,
    output logic [fsqm_pkg::OUT_USER_W-1:0]     o_out_user
);
    import fsqm_pkg::*;

    localparam int MEM_W = SEQ_W + LEN_W;

    logic [LEN_W-1:0]  r_cap;
    logic              r_latest;

    t_action           r_act;
    logic              r_present;
    logic [LEN_W-1:0]  r_len;
    logic [SEL_W-1:0]  r_sel;
    logic              r_ok;

    t_slot_st          r_st [SLOTS];
    t_slot_st          n_st [SLOTS];
    logic [MEM_W-1:0]  r_mem [SLOTS];

    logic [MEM_W-1:0]  r_rd_data;
    logic [SLOT_W-1:0] r_rd_idx;
    logic              r_cmp_vld;

    logic              r_best_vld;
    logic [SLOT_W-1:0] r_best_idx;
    logic [SEQ_W-1:0]  r_best_seq;
    logic [LEN_W-1:0]  r_best_len;

    logic [CNT_W-1:0]  r_pend;
    logic [CNT_W-1:0]  n_pend;
    logic [CNT_W-1:0]  r_peak;
    logic [CNT_W-1:0]  n_peak;
    logic [SEQ_W-1:0]  r_pub;
    logic [SEQ_W-1:0]  n_pub;
    logic [SEQ_W-1:0]  r_drop;
    logic [SEQ_W-1:0]  n_drop;
    logic [SEQ_W-1:0]  r_dec;
    logic [SEQ_W-1:0]  n_dec;
    logic [SEQ_W-1:0]  r_fail;
    logic [SEQ_W-1:0]  n_fail;

    logic [SLOTS-1:0]  w_pend_mask;
    logic              w_pend_any;
    logic              w_free_any;
    logic [SLOT_W-1:0] w_free_idx;
    logic              w_sel_ok;
    logic [SLOT_W-1:0] w_sel_idx;
    logic              w_reject;
    logic [SLOT_W-1:0] w_rd_addr;
    logic [SEQ_W-1:0]  w_rd_seq;
    logic [LEN_W-1:0]  w_rd_len;
    logic              w_better;
    logic              w_take_cand;
    t_slot_st          w_need;
    logic [SLOT_W-1:0] w_pick;

    t_result           w_res_status;
    logic [SLOT_W-1:0] w_res_idx;
    logic [SEQ_W-1:0]  w_res_seq;
    logic [LEN_W-1:0]  w_res_len;
    logic [CNT_W-1:0]  w_res_drops;
    logic              w_mem_we;
    logic [SLOT_W-1:0] w_mem_addr;
    logic [MEM_W-1:0]  w_mem_wdata;

    always_comb begin
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            w_pend_mask[i] = (r_st[i] == ST_PENDING);
            if (r_st[i] == ST_FREE) begin
                w_free_any = 1'b1;
                w_free_idx = SLOT_W'(i);
            end
        end
    end

    assign w_pend_any = |w_pend_mask;
    assign w_sel_ok   = (32'(r_sel) < SLOTS);
    assign w_sel_idx  = SLOT_W'(r_sel);
    assign w_reject   = !r_present || (r_len > r_cap) || (r_len < MIN_FRAME_BYTES);

    assign o_sts.need_scan = ((r_act == ACT_BEGIN) && !w_reject && !w_free_any && w_pend_any)
                          || ((r_act == ACT_TAKE) && w_pend_any);

    assign w_rd_addr = i_cmd.scan_rd ? i_cmd.scan_addr : w_sel_idx;
    assign w_rd_seq  = r_rd_data[MEM_W-1:LEN_W];
    assign w_rd_len  = r_rd_data[LEN_W-1:0];

    // A later slot replaces the candidate only on a strict win, so ties keep the lower index.
    // Only a take in latest mode looks for the newest frame; an overwrite always evicts
    // the oldest one.
    assign w_better    = !r_best_vld || ((r_latest && (r_act == ACT_TAKE))
                                         ? (w_rd_seq > r_best_seq)
                                         : (w_rd_seq < r_best_seq));
    assign w_take_cand = r_cmp_vld && (r_st[r_rd_idx] == ST_PENDING) && w_better;

    assign w_need = (r_act == ACT_END) ? ST_WRITING : ST_DECODING;
    assign w_pick = w_free_any ? w_free_idx : r_best_idx;

    always_comb begin
        n_st         = r_st;
        n_pend       = r_pend;
        n_peak       = r_peak;
        n_pub        = r_pub;
        n_drop       = r_drop;
        n_dec        = r_dec;
        n_fail       = r_fail;
        w_res_status = RES_OK;
        w_res_idx    = '0;
        w_res_seq    = '0;
        w_res_len    = '0;
        w_res_drops  = '0;
        w_mem_we     = 1'b0;
        w_mem_addr   = w_pick;
        w_mem_wdata  = '0;
        case (r_act)
            ACT_BEGIN: begin
                n_pub = r_pub + 1'b1;
                if (w_reject) begin
                    w_res_status = RES_REJECT;
                    w_res_drops  = CNT_W'(1);
                    n_drop       = r_drop + 1'b1;
                end else if (!w_free_any && !w_pend_any) begin
                    w_res_status = RES_NO_SLOT;
                    w_res_drops  = CNT_W'(1);
                    n_drop       = r_drop + 1'b1;
                end else begin
                    if (!w_free_any) begin
                        n_pend      = r_pend - 1'b1;
                        w_res_drops = CNT_W'(1);
                        n_drop      = r_drop + 1'b1;
                    end
                    n_st[w_pick] = ST_WRITING;
                    w_mem_we     = 1'b1;
                    w_mem_wdata  = {n_pub, r_len};
                    w_res_idx    = w_pick;
                    w_res_seq    = n_pub;
                    w_res_len    = r_len;
                end
            end
            ACT_END, ACT_RELEASE: begin
                if (!w_sel_ok || (r_st[w_sel_idx] != w_need)) begin
                    w_res_status = RES_WRONG_STATE;
                end else begin
                    w_res_idx = w_sel_idx;
                    w_res_seq = w_rd_seq;
                    w_res_len = w_rd_len;
                    if (r_act == ACT_END) begin
                        n_st[w_sel_idx] = ST_PENDING;
                        n_pend          = r_pend + 1'b1;
                        if (n_pend > r_peak) begin
                            n_peak = n_pend;
                        end
                    end else begin
                        n_st[w_sel_idx] = ST_FREE;
                        if (r_ok) begin
                            n_dec = r_dec + 1'b1;
                        end else begin
                            n_fail = r_fail + 1'b1;
                        end
                    end
                end
            end
            ACT_TAKE: begin
                if (!w_pend_any) begin
                    w_res_status = RES_NONE_PENDING;
                end else begin
                    if (r_latest) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (w_pend_mask[i]) begin
                                n_st[i] = ST_FREE;
                            end
                        end
                        w_res_drops = r_pend - 1'b1;
                        n_drop      = r_drop + SEQ_W'(w_res_drops);
                        n_pend      = '0;
                    end else begin
                        n_pend = r_pend - 1'b1;
                    end
                    n_st[r_best_idx] = ST_DECODING;
                    w_res_idx        = r_best_idx;
                    w_res_seq        = r_best_seq;
                    w_res_len        = r_best_len;
                end
            end
            default: begin
                w_res_status = RES_WRONG_STATE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_cmd.scan_addr;
        if (i_cmd.load) begin
            r_act     <= t_action'(i_in_user);
            r_present <= i_in_data[0];
            r_len     <= i_in_data[LEN_W:1];
            r_sel     <= i_in_data[LEN_W+SEL_W:LEN_W+1];
            r_ok      <= i_in_data[LEN_W+SEL_W+1];
        end
        if (w_take_cand) begin
            r_best_idx <= r_rd_idx;
            r_best_seq <= w_rd_seq;
            r_best_len <= w_rd_len;
        end
        if (i_cmd.apply) begin
            o_out_user <= w_res_status;
            o_out_data <= {{OUT_PAD_W{1'b0}}, n_fail, n_dec, n_drop, n_pub,
                           DROP_W'(n_peak), DROP_W'(n_pend), DROP_W'(w_res_drops),
                           w_res_len, w_res_seq, IDX_OUT_W'(w_res_idx)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_RESET;
            r_latest   <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_best_vld <= 1'b0;
            r_pend     <= '0;
            r_peak     <= '0;
            r_pub      <= '0;
            r_drop     <= '0;
            r_dec      <= '0;
            r_fail     <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_st[i] <= ST_FREE;
            end
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_CAPACITY: r_cap <= i_cfg_data;
                    CFG_LATEST:   r_latest <= i_cfg_data[0];
                    default:      ;
                endcase
            end
            r_cmp_vld <= i_cmd.scan_rd;
            if (i_cmd.scan_clr) begin
                r_best_vld <= 1'b0;
            end else if (w_take_cand) begin
                r_best_vld <= 1'b1;
            end
            if (i_cmd.apply) begin
                r_st   <= n_st;
                r_pend <= n_pend;
                r_peak <= n_peak;
                r_pub  <= n_pub;
                r_drop <= n_drop;
                r_dec  <= n_dec;
                r_fail <= n_fail;
            end
        end
    end

endmodule

@@ hdl/frame_slot_queue_manager.sv @@
// ----------------------------------------------------------------------------
// frame_slot_queue_manager
// Pool of frame slots between a frame producer and one decoder. Each input
// transaction is one action (begin publish, end publish, take, release) and
// produces exactly one result transaction. An action that needs no search
// is loaded, read and then applied once the result register is free. A begin
// publish that must overwrite the oldest pending slot, and every take with
// something pending, first searches the slot sequence memory one entry per
// cycle. The configuration port is always ready; it is to be written only
// while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module frame_slot_queue_manager (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // frame_present, frame_length, slot_select, decode_ok, zero padding
    input  logic [fsqm_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // action
    input  logic [fsqm_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // slot_index, sequence_res, length_out, dropped_now, pending_now,
    // peak_pending_out, published_total, dropped_total, decoded_total,
    // failed_total, zero padding
    output logic [fsqm_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // status
    output logic [fsqm_pkg::OUT_USER_W-1:0] o_m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fsqm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fsqm_pkg::LEN_W-1:0]      i_cfg_data
);
    import fsqm_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    fsqm_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_cmd           (w_cmd),
        .i_sts           (w_sts)
    );

    fsqm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_one_action_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("Input accepted again while an action is in progress.");

    a_apply_into_free_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.apply |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("Result written over an untaken result.");

    a_apply_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.apply |=> o_m_axis_tvalid)
        else $error("Completed action did not present a result.");

    a_exclusive_commands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.scan_rd, w_cmd.apply, w_cmd.scan_clr}))
        else $error("Conflicting datapath commands.");
`endif

endmodule

@@ tb/tb_frame_slot_queue_manager.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_slot_queue_manager
// Self-checking bench for the frame slot queue manager. A directed table hits
// the empty pool, bad frames, length extremes and every slot state error, then
// a series of configuration phases sends mostly well-formed publish, take and
// release sequences with some noise. A behavioral slot pool model predicts
// every result transaction, which is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_frame_slot_queue_manager;

    import fsqm_pkg::*;

    typedef struct packed {
        t_action          act;
        logic             present;
        logic [LEN_W-1:0] flen;
        logic [SEL_W-1:0] sel;
        logic             ok;
    } t_request;

    typedef struct packed {
        t_request req;
        t_result  status;
    } t_directed_row;

    typedef struct packed {
        t_result              status;
        logic [IDX_OUT_W-1:0] slot;
        logic [SEQ_W-1:0]     seq;
        logic [LEN_W-1:0]     len;
        logic [DROP_W-1:0]    drops;
        logic [3:0]           pend;
        logic [3:0]           peak;
        logic [31:0]          pub;
        logic [31:0]          drp;
        logic [31:0]          dec;
        logic [31:0]          fail;
    } t_outcome;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CAPACITY;
    logic [LEN_W-1:0]      cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_ready;

    // Behavioral copy of the slot pool.
    t_slot_st         pool_state [SLOTS];
    logic [SEQ_W-1:0] pool_seq   [SLOTS];
    logic [LEN_W-1:0] pool_len   [SLOTS];
    logic [3:0]       n_pending;
    logic [3:0]       n_peak;
    logic [31:0]      tot_published;
    logic [31:0]      tot_dropped;
    logic [31:0]      tot_decoded;
    logic [31:0]      tot_failed;
    logic [LEN_W-1:0] cap_reg;
    logic             latest_reg;

    t_outcome predicted_outcomes[$];
    int       mismatch_cnt = 0;

    t_directed_row directed_rows [19] = '{
        '{'{ACT_TAKE,    1'b0, 23'd0,       3'd0, 1'b0}, RES_NONE_PENDING},
        '{'{ACT_RELEASE, 1'b0, 23'd0,       3'd0, 1'b1}, RES_WRONG_STATE},
        '{'{ACT_END,     1'b0, 23'd0,       3'd7, 1'b0}, RES_WRONG_STATE},
        '{'{ACT_BEGIN,   1'b0, 23'd100,     3'd0, 1'b0}, RES_REJECT},
        '{'{ACT_BEGIN,   1'b1, 23'd3,       3'd0, 1'b0}, RES_REJECT},
        '{'{ACT_BEGIN,   1'b1, 23'h7FFFFF,  3'd7, 1'b1}, RES_REJECT},
        '{'{ACT_BEGIN,   1'b1, 23'h400001,  3'd0, 1'b0}, RES_REJECT},
        '{'{ACT_BEGIN,   1'b1, 23'd4,       3'd0, 1'b0}, RES_OK},
        '{'{ACT_BEGIN,   1'b1, 23'h400000,  3'd0, 1'b0}, RES_OK},
        '{'{ACT_END,     1'b0, 23'd0,       3'd1, 1'b0}, RES_OK},
        '{'{ACT_END,     1'b0, 23'd0,       3'd0, 1'b0}, RES_OK},
        '{'{ACT_END,     1'b0, 23'd0,       3'd0, 1'b0}, RES_WRONG_STATE},
        '{'{ACT_TAKE,    1'b0, 23'd0,       3'd0, 1'b0}, RES_OK},
        '{'{ACT_RELEASE, 1'b0, 23'd0,       3'd1, 1'b1}, RES_WRONG_STATE},
        '{'{ACT_RELEASE, 1'b0, 23'd0,       3'd0, 1'b1}, RES_OK},
        '{'{ACT_TAKE,    1'b0, 23'd0,       3'd0, 1'b0}, RES_OK},
        '{'{ACT_RELEASE, 1'b0, 23'd0,       3'd1, 1'b0}, RES_OK},
        '{'{ACT_TAKE,    1'b1, 23'h7FFFFF,  3'd7, 1'b1}, RES_NONE_PENDING},
        '{'{ACT_RELEASE, 1'b1, 23'h7FFFFF,  3'd1, 1'b1}, RES_WRONG_STATE}
    };

    frame_slot_queue_manager dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void reset_pool();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            pool_state[i] = ST_FREE;
            pool_seq[i]   = '0;
            pool_len[i]   = '0;
        end
        n_pending     = '0;
        n_peak        = '0;
        tot_published = '0;
        tot_dropped   = '0;
        tot_decoded   = '0;
        tot_failed    = '0;
        cap_reg       = CAP_RESET;
        latest_reg    = 1'b0;
    endfunction

    // Pending slot with the smallest or, for newest, the largest sequence.
    // The strict compare keeps the lowest index on a tie.
    function automatic int find_pending_slot(input logic newest);
        int best;
        int i;
        best = -1;
        for (i = 0; i < SLOTS; i++) begin
            if (pool_state[i] == ST_PENDING) begin
                if (best < 0 || (newest ? pool_seq[i] > pool_seq[best]
                                        : pool_seq[i] < pool_seq[best]))
                    best = i;
            end
        end
        return best;
    endfunction

    function automatic t_outcome predict_action(input t_request req);
        t_outcome r;
        t_slot_st need;
        int       pick;
        int       i;
        r        = '0;
        r.status = RES_OK;
        case (req.act)
            ACT_BEGIN: begin
                tot_published++;
                pick = -1;
                for (i = 0; i < SLOTS; i++)
                    if (pick < 0 && pool_state[i] == ST_FREE)
                        pick = i;
                if (pick < 0)
                    pick = find_pending_slot(1'b0);
                if (!req.present || req.flen > cap_reg || req.flen < MIN_FRAME_BYTES) begin
                    r.status = RES_REJECT;
                    r.drops  = 4'd1;
                    tot_dropped++;
                end else if (pick < 0) begin
                    r.status = RES_NO_SLOT;
                    r.drops  = 4'd1;
                    tot_dropped++;
                end else begin
                    if (pool_state[pick] == ST_PENDING) begin
                        n_pending--;
                        r.drops = 4'd1;
                        tot_dropped++;
                    end
                    pool_state[pick] = ST_WRITING;
                    pool_seq[pick]   = tot_published;
                    pool_len[pick]   = req.flen;
                    r.slot = IDX_OUT_W'(pick);
                    r.seq  = tot_published;
                    r.len  = req.flen;
                end
            end
            ACT_END, ACT_RELEASE: begin
                need = (req.act == ACT_END) ? ST_WRITING : ST_DECODING;
                if (int'(req.sel) >= SLOTS || pool_state[req.sel] != need) begin
                    r.status = RES_WRONG_STATE;
                end else begin
                    r.slot = req.sel;
                    r.seq  = pool_seq[req.sel];
                    r.len  = pool_len[req.sel];
                    if (req.act == ACT_END) begin
                        pool_state[req.sel] = ST_PENDING;
                        n_pending++;
                        if (n_pending > n_peak)
                            n_peak = n_pending;
                    end else begin
                        pool_state[req.sel] = ST_FREE;
                        if (req.ok)
                            tot_decoded++;
                        else
                            tot_failed++;
                    end
                end
            end
            default: begin
                pick = find_pending_slot(latest_reg);
                if (pick < 0) begin
                    r.status = RES_NONE_PENDING;
                end else begin
                    if (latest_reg) begin
                        for (i = 0; i < SLOTS; i++) begin
                            if (i != pick && pool_state[i] == ST_PENDING) begin
                                pool_state[i] = ST_FREE;
                                n_pending--;
                                r.drops++;
                                tot_dropped++;
                            end
                        end
                    end
                    pool_state[pick] = ST_DECODING;
                    n_pending--;
                    r.slot = IDX_OUT_W'(pick);
                    r.seq  = pool_seq[pick];
                    r.len  = pool_len[pick];
                end
            end
        endcase
        r.pend = n_pending;
        r.peak = n_peak;
        r.pub  = tot_published;
        r.drp  = tot_dropped;
        r.dec  = tot_decoded;
        r.fail = tot_failed;
        return r;
    endfunction

    // Mostly actions that fit the current pool state, with random content;
    // one in ten is left fully random.
    function automatic t_request make_action(input int begin_pct);
        t_request req;
        t_slot_st want;
        int       cand[$];
        int       capv;
        int       r;
        int       i;
        capv        = int'(cap_reg);
        req.act     = t_action'($urandom_range(0, 3));
        req.present = ($urandom_range(0, 15) != 0);
        req.sel     = SEL_W'($urandom_range(0, 7));
        req.ok      = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 9);
        if (r == 0) begin
            req.flen = LEN_W'($urandom);
        end else if (r == 1) begin
            case ($urandom_range(0, 3))
                0:       req.flen = LEN_W'($urandom_range(0, 3));
                1:       req.flen = cap_reg;
                2:       req.flen = cap_reg + 1'b1;
                default: req.flen = CAP_RESET;
            endcase
        end else if (capv < 4) begin
            req.flen = MIN_FRAME_BYTES;
        end else if (capv > 4096 && $urandom_range(0, 3) != 0) begin
            req.flen = LEN_W'($urandom_range(4, 4096));
        end else begin
            req.flen = LEN_W'($urandom_range(4, capv));
        end
        if ($urandom_range(0, 9) == 0)
            return req;
        r = $urandom_range(0, 99);
        if (r < begin_pct)
            req.act = ACT_BEGIN;
        else if (r < begin_pct + (100 - begin_pct) / 3)
            req.act = ACT_END;
        else if (r < begin_pct + 2 * (100 - begin_pct) / 3)
            req.act = ACT_TAKE;
        else
            req.act = ACT_RELEASE;
        if (req.act == ACT_END || req.act == ACT_RELEASE) begin
            want = (req.act == ACT_END) ? ST_WRITING : ST_DECODING;
            for (i = 0; i < SLOTS; i++)
                if (pool_state[i] == want)
                    cand.push_back(i);
            if (cand.size() != 0)
                req.sel = SEL_W'(cand[$urandom_range(0, cand.size() - 1)]);
        end
        return req;
    endfunction

    task automatic offer_action(input t_request req, input logic typed, input t_result status);
        t_outcome want;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, req.ok, req.sel, req.flen, req.present};
        s_tuser  <= req.act;
        do @(posedge clk); while (!s_tready);
        want = predict_action(req);
        if (typed)
            want.status = status;
        predicted_outcomes.push_back(want);
    endtask

    task automatic wait_drained();
        while (predicted_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_settings(input logic [LEN_W-1:0] capacity, input logic latest);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= capacity;
        do @(posedge clk); while (!cfg_ready);
        cap_reg = capacity;
        cfg_index <= CFG_LATEST;
        cfg_data  <= {(LEN_W-1)'($urandom), latest};
        do @(posedge clk); while (!cfg_ready);
        latest_reg = latest;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] capacity, input logic latest,
                             input int begin_pct, input int n_items, input logic steady);
        int k;
        wait_drained();
        load_settings(capacity, latest);
        for (k = 0; k < n_items; k++) begin
            if (!steady && $urandom_range(0, 9) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            offer_action(make_action(begin_pct), 1'b0, RES_OK);
        end
        s_tvalid <= 1'b0;
    endtask

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
        end
    endfunction

    function automatic void check_outcome(input t_outcome got);
        t_outcome want;
        if (predicted_outcomes.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: result transaction with none predicted", $realtime);
        end else begin
            want = predicted_outcomes.pop_front();
            check_field("status",           32'(want.status), 32'(got.status));
            check_field("slot_index",       32'(want.slot),   32'(got.slot));
            check_field("sequence_res",     want.seq,         got.seq);
            check_field("length_out",       32'(want.len),    32'(got.len));
            check_field("dropped_now",      32'(want.drops),  32'(got.drops));
            check_field("pending_now",      32'(want.pend),   32'(got.pend));
            check_field("peak_pending_out", 32'(want.peak),   32'(got.peak));
            check_field("published_total",  want.pub,         got.pub);
            check_field("dropped_total",    want.drp,         got.drp);
            check_field("decoded_total",    want.dec,         got.dec);
            check_field("failed_total",     want.fail,        got.fail);
        end
    endfunction

    // Result side: random stalls, a quiet stretch, and two long hold-offs that
    // back the block up into its input.
    initial begin : result_sink
        int       results_seen;
        int       hold_left;
        int       last_hold;
        t_outcome got;
        results_seen = 0;
        hold_left    = 0;
        last_hold    = -1;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                got.status = t_result'(m_tuser);
                got.slot   = m_tdata[2:0];
                got.seq    = m_tdata[34:3];
                got.len    = m_tdata[57:35];
                got.drops  = m_tdata[61:58];
                got.pend   = m_tdata[65:62];
                got.peak   = m_tdata[69:66];
                got.pub    = m_tdata[101:70];
                got.drp    = m_tdata[133:102];
                got.dec    = m_tdata[165:134];
                got.fail   = m_tdata[197:166];
                check_outcome(got);
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if ((results_seen == 150 || results_seen == 900)
                         && last_hold != results_seen) begin
                hold_left = 400;
                last_hold = results_seen;
            end
            if (hold_left > 0)
                m_tready <= 1'b0;
            else if (results_seen >= 450 && results_seen < 650)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 9) != 0);
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int r;
        reset_pool();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (r = 0; r < 19; r++) begin
            if ($urandom_range(0, 9) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            offer_action(directed_rows[r].req, 1'b1, directed_rows[r].status);
        end
        s_tvalid <= 1'b0;
        run_phase(CAP_RESET, 1'b0, 40, 200, 1'b0);
        run_phase(LEN_W'($urandom_range(4, 4096)), 1'b1, 55, 200, 1'b0);
        run_phase(LEN_W'(1), 1'b0, 50, 40, 1'b0);
        run_phase(MIN_FRAME_BYTES, 1'b1, 60, 120, 1'b0);
        run_phase(CAP_RESET, 1'b1, 70, 220, 1'b1);
        run_phase(LEN_W'($urandom_range(1, 4194304)), 1'b0, 60, 220, 1'b0);
        run_phase(LEN_W'($urandom_range(4, 64)), 1'b0, 45, 100, 1'b0);
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0 && predicted_outcomes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/fsqm_pkg.sv
hdl/fsqm_ctrl.sv
hdl/fsqm_datapath.sv
hdl/frame_slot_queue_manager.sv
tb/tb_frame_slot_queue_manager.sv
